### design/cts_pkg.sv
package cts_pkg;

  localparam int unsigned MAX_TOKENS = 16;
  localparam int unsigned MAX_LEN    = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_DELIM   = 2'd1,
    REG_MAX_TOK = 2'd2,
    REG_MAX_LEN = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_WS    = 2'd0,
    MODE_DELIM = 2'd1,
    MODE_TRIM  = 2'd2,
    MODE_WORDS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_IN      = 2'd1,
    PH_FULL    = 2'd2
  } phase_e;

  localparam mode_e      RST_MODE    = MODE_WS;
  localparam logic [7:0] RST_DELIM   = 8'd44;
  localparam logic [4:0] RST_MAX_TOK = 5'd16;
  localparam logic [5:0] RST_MAX_LEN = 6'd32;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] delim;
    logic [4:0] max_tok;
    logic [5:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] token_index;
    logic [4:0] position;
    logic [7:0] out_byte;
    logic [5:0] token_length;
    logic [4:0] token_count;
    logic       last;
  } res_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
  endfunction

endpackage

### design/cts_core.sv
module cts_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [7:0]         byte_i,
  input  cts_pkg::cfg_t      cfg_i,
  output cts_pkg::res_t      res0_o,
  output cts_pkg::res_t      res1_o,
  output logic [1:0]         num_o
);

  cts_pkg::phase_e phase_q, phase_d;
  logic [4:0] tok_q, tok_d;
  logic [5:0] cc_q, cc_d;
  logic [5:0] kept_q, kept_d;

  logic [4:0] lim_tok;
  logic [5:0] lim_len;

  always_comb begin
    if (cfg_i.max_tok > 5'(cts_pkg::MAX_TOKENS)) lim_tok = 5'(cts_pkg::MAX_TOKENS);
    else lim_tok = cfg_i.max_tok;
    if (cfg_i.max_len > 6'(cts_pkg::MAX_LEN)) lim_len = 6'(cts_pkg::MAX_LEN);
    else if (cfg_i.max_len == 6'd0) lim_len = 6'd1;
    else lim_len = cfg_i.max_len;
  end

  always_comb begin
    logic       op_wr;
    logic       op_cl;
    logic       sep;
    logic       trim;
    logic [5:0] cc_b;
    logic [5:0] kp_b;
    logic [5:0] cc1;
    logic [5:0] kp1;
    cts_pkg::res_t r0;
    cts_pkg::res_t r1;
    logic [1:0] n;

    op_wr = 1'b0;
    op_cl = 1'b0;
    cc_b  = cc_q;
    kp_b  = kept_q;
    trim  = (cfg_i.mode == cts_pkg::MODE_TRIM);
    sep   = (cfg_i.mode == cts_pkg::MODE_WS) ? cts_pkg::is_ws(byte_i)
                                             : !cts_pkg::is_letter(byte_i);
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    phase_d = phase_q;
    tok_d   = tok_q;
    cc_d    = cc_q;
    kept_d  = kept_q;
    cc1 = 6'd0;
    kp1 = 6'd0;

    if (byte_i == cts_pkg::CH_NUL) begin
      // end of line: close an open token, then report the count
      if (phase_q == cts_pkg::PH_IN) begin
        r0.kind         = cts_pkg::KIND_CLOSE;
        r0.token_index  = tok_q[3:0];
        r0.token_length = trim ? kept_q : cc_q;
        r1.kind         = cts_pkg::KIND_FINISH;
        r1.token_count  = tok_q + 5'd1;
        n = 2'd2;
      end else begin
        r0.kind        = cts_pkg::KIND_FINISH;
        r0.token_count = tok_q;
        n = 2'd1;
      end
      phase_d = cts_pkg::PH_BETWEEN;
      tok_d   = 5'd0;
      cc_d    = 6'd0;
      kept_d  = 6'd0;
    end else if (tok_q >= lim_tok) begin
      // token limit reached, rest of the line is dropped
    end else if (cfg_i.mode == cts_pkg::MODE_WS || cfg_i.mode == cts_pkg::MODE_WORDS) begin
      case (phase_q)
        cts_pkg::PH_IN: begin
          if (sep) op_cl = 1'b1;
          else op_wr = 1'b1;
        end
        cts_pkg::PH_FULL: begin
          if (sep) phase_d = cts_pkg::PH_BETWEEN;
        end
        default: begin
          if (!sep) op_wr = 1'b1;
        end
      endcase
    end else begin
      if (phase_q == cts_pkg::PH_IN) begin
        if (byte_i == cfg_i.delim) op_cl = 1'b1;
        else op_wr = 1'b1;
      end else if (phase_q == cts_pkg::PH_FULL && byte_i == cfg_i.delim) begin
        phase_d = cts_pkg::PH_BETWEEN;
      end else if (trim && cts_pkg::is_ws(byte_i)) begin
        phase_d = cts_pkg::PH_BETWEEN;
      end else begin
        // fresh token, possibly empty
        cc_b = 6'd0;
        kp_b = 6'd0;
        if (byte_i == cfg_i.delim) op_cl = 1'b1;
        else op_wr = 1'b1;
      end
    end

    if (op_cl) begin
      r0.kind         = cts_pkg::KIND_CLOSE;
      r0.token_index  = tok_q[3:0];
      r0.token_length = trim ? kp_b : cc_b;
      n       = 2'd1;
      tok_d   = tok_q + 5'd1;
      cc_d    = 6'd0;
      kept_d  = 6'd0;
      phase_d = cts_pkg::PH_BETWEEN;
    end

    if (op_wr) begin
      cc1 = cc_b + 6'd1;
      kp1 = cts_pkg::is_ws(byte_i) ? kp_b : cc1;
      r0.kind        = cts_pkg::KIND_WRITE;
      r0.token_index = tok_q[3:0];
      r0.position    = cc_b[4:0];
      r0.out_byte    = byte_i;
      if (cc1 >= lim_len) begin
        // token full: closed in the same step
        r1.kind         = cts_pkg::KIND_CLOSE;
        r1.token_index  = tok_q[3:0];
        r1.token_length = trim ? kp1 : cc1;
        n       = 2'd2;
        tok_d   = tok_q + 5'd1;
        cc_d    = 6'd0;
        kept_d  = 6'd0;
        phase_d = cts_pkg::PH_FULL;
      end else begin
        n       = 2'd1;
        cc_d    = cc1;
        kept_d  = kp1;
        phase_d = cts_pkg::PH_IN;
      end
    end

    r0.last = (n == 2'd1);
    r1.last = 1'b1;
    res0_o  = r0;
    res1_o  = r1;
    num_o   = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cts_pkg::PH_BETWEEN;
      tok_q   <= 5'd0;
      cc_q    <= 6'd0;
      kept_q  <= 6'd0;
    end else if (go_i) begin
      phase_q <= phase_d;
      tok_q   <= tok_d;
      cc_q    <= cc_d;
      kept_q  <= kept_d;
    end
  end

endmodule

### design/cts_res_fifo.sv
module cts_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_num_i,
  input  cts_pkg::res_t  push0_i,
  input  cts_pkg::res_t  push1_i,
  output logic           room2_o,
  output logic           valid_o,
  input  logic           stall_i,
  output cts_pkg::res_t  head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  cts_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= (PtrW + 1)'(Depth - 2));
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_num_i);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + (PtrW + 1)'(push_num_i) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_num_i == 2'd2) mem_q[wr_q + PtrW'(1)] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### design/configurable_token_splitter_top.sv
// path: input register, then a four-entry result queue whose head is shown
// throughput: one byte per cycle while the queue has room for two results; a byte gives up
// to two results, drained one per cycle unless stalled, so two-result bytes in a row stall the input
// reset: asynchronous, active low; clears line state, queue and registers to their
// reset values (whitespace mode, delimiter ',', 16 tokens, 32 bytes)
module configurable_token_splitter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [3:0] token_index_o,
  output logic [4:0] position_o,
  output logic [7:0] out_byte_o,
  output logic [5:0] token_length_o,
  output logic [4:0] token_count_o,
  output logic       last_o
);

  cts_pkg::cfg_t cfg_q;
  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          room2;
  logic          go;
  logic [1:0]    num;
  cts_pkg::res_t res0, res1, head;

  assign go         = in_vld_q && room2;
  assign in_stall_o = in_vld_q && !room2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= cts_pkg::RST_MODE;
      cfg_q.delim   <= cts_pkg::RST_DELIM;
      cfg_q.max_tok <= cts_pkg::RST_MAX_TOK;
      cfg_q.max_len <= cts_pkg::RST_MAX_LEN;
    end else if (cfg_we_i) begin
      case (cts_pkg::reg_idx_e'(cfg_idx_i))
        cts_pkg::REG_MODE:    cfg_q.mode    <= cts_pkg::mode_e'(cfg_data_i[1:0]);
        cts_pkg::REG_DELIM:   cfg_q.delim   <= cfg_data_i;
        cts_pkg::REG_MAX_TOK: cfg_q.max_tok <= cfg_data_i[4:0];
        cts_pkg::REG_MAX_LEN: cfg_q.max_len <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // input register, refilled whenever the held byte moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= in_byte_i;
  end

  cts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .byte_i (in_byte_q),
    .cfg_i  (cfg_q),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (num)
  );

  cts_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (go ? num : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .head_o     (head)
  );

  assign kind_o         = head.kind;
  assign token_index_o  = head.token_index;
  assign position_o     = head.position;
  assign out_byte_o     = head.out_byte;
  assign token_length_o = head.token_length;
  assign token_count_o  = head.token_count;
  assign last_o         = head.last;

endmodule

### dv/tb_configurable_token_splitter_top.sv
`timescale 1ns / 100ps

module tb_configurable_token_splitter_top;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = cts_pkg::REG_MODE;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i  = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [3:0] token_index_o;
  logic [4:0] position_o;
  logic [7:0] out_byte_o;
  logic [5:0] token_length_o;
  logic [4:0] token_count_o;
  logic       last_o;

  configurable_token_splitter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .token_index_o  (token_index_o),
    .position_o     (position_o),
    .out_byte_o     (out_byte_o),
    .token_length_o (token_length_o),
    .token_count_o  (token_count_o),
    .last_o         (last_o)
  );

  always #2 clk_i = ~clk_i;

  // splitter settings as last written
  cts_pkg::mode_e sp_mode    = cts_pkg::RST_MODE;
  logic [7:0]     sp_delim   = cts_pkg::RST_DELIM;
  logic [4:0]     sp_max_tok = cts_pkg::RST_MAX_TOK;
  logic [5:0]     sp_max_len = cts_pkg::RST_MAX_LEN;

  // line state
  cts_pkg::phase_e ln_phase = cts_pkg::PH_BETWEEN;
  logic [4:0]      ln_token = '0;
  logic [5:0]      ln_count = '0;
  logic [5:0]      ln_kept  = '0;

  cts_pkg::res_t token_events_q[$];
  cts_pkg::res_t byte_events[$];
  int   live_bytes  = 0;
  int   fault_count = 0;

  bit   steady        = 1'b0;
  bit   pressure_req  = 1'b0;
  int   pressure_left = 0;

  function automatic bit blank(logic [7:0] c);
    return (c == cts_pkg::CH_SPACE) || (c == cts_pkg::CH_TAB) ||
           (c == cts_pkg::CH_LF) || (c == cts_pkg::CH_CR);
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic void add_event(cts_pkg::kind_e k, logic [3:0] idx, logic [4:0] pos,
                                    logic [7:0] c, logic [5:0] len, logic [4:0] cnt);
    cts_pkg::res_t r;
    r.kind         = k;
    r.token_index  = idx;
    r.position     = pos;
    r.out_byte     = c;
    r.token_length = len;
    r.token_count  = cnt;
    r.last         = 1'b0;
    byte_events.push_back(r);
  endfunction

  function automatic void close_token();
    add_event(cts_pkg::KIND_CLOSE, ln_token[3:0], '0, '0,
              (sp_mode == cts_pkg::MODE_TRIM) ? ln_kept : ln_count, '0);
    ln_token = ln_token + 1'b1;
    ln_count = '0;
    ln_kept  = '0;
    ln_phase = cts_pkg::PH_BETWEEN;
  endfunction

  function automatic void store_byte(logic [7:0] c, int len_cap);
    add_event(cts_pkg::KIND_WRITE, ln_token[3:0], ln_count[4:0], c, '0, '0);
    ln_count = ln_count + 1'b1;
    // trailing whitespace does not move the trimmed length on
    if (!blank(c)) ln_kept = ln_count;
    if (ln_count >= len_cap) begin
      close_token();
      ln_phase = cts_pkg::PH_FULL;
    end else begin
      ln_phase = cts_pkg::PH_IN;
    end
  endfunction

  function automatic void split_byte(logic [7:0] c);
    int            tok_cap;
    int            len_cap;
    bit            sep;
    cts_pkg::res_t tail;
    tok_cap = (sp_max_tok > cts_pkg::MAX_TOKENS) ? cts_pkg::MAX_TOKENS : sp_max_tok;
    len_cap = (sp_max_len > cts_pkg::MAX_LEN) ? cts_pkg::MAX_LEN : sp_max_len;
    if (len_cap == 0) len_cap = 1;
    live_bytes++;
    if (c == cts_pkg::CH_NUL) begin
      if (ln_phase == cts_pkg::PH_IN) close_token();
      add_event(cts_pkg::KIND_FINISH, '0, '0, '0, '0, ln_token);
      ln_phase = cts_pkg::PH_BETWEEN;
      ln_token = '0;
      ln_count = '0;
      ln_kept  = '0;
    end else if (ln_token >= tok_cap) begin
      // token limit reached, rest of the line is dropped
    end else begin
      if (sp_mode == cts_pkg::MODE_WS || sp_mode == cts_pkg::MODE_WORDS) begin
        sep = (sp_mode == cts_pkg::MODE_WS) ? blank(c) : !alpha(c);
        if (ln_phase == cts_pkg::PH_IN) begin
          if (sep) close_token();
          else store_byte(c, len_cap);
        end else if (ln_phase == cts_pkg::PH_FULL) begin
          if (sep) ln_phase = cts_pkg::PH_BETWEEN;
        end else if (!sep) begin
          store_byte(c, len_cap);
        end
      end else begin
        if (ln_phase == cts_pkg::PH_IN) begin
          if (c == sp_delim) close_token();
          else store_byte(c, len_cap);
        end else if (ln_phase == cts_pkg::PH_FULL && c == sp_delim) begin
          ln_phase = cts_pkg::PH_BETWEEN;
        end else if (sp_mode == cts_pkg::MODE_TRIM && blank(c)) begin
          ln_phase = cts_pkg::PH_BETWEEN;
        end else begin
          // a delimiter here makes an empty token
          ln_count = '0;
          ln_kept  = '0;
          if (c == sp_delim) close_token();
          else store_byte(c, len_cap);
        end
      end
    end
    if (byte_events.size() != 0) begin
      tail = byte_events.pop_back();
      tail.last = 1'b1;
      byte_events.push_back(tail);
    end
    while (byte_events.size() != 0) token_events_q.push_back(byte_events.pop_front());
  endfunction

  function automatic string show(cts_pkg::res_t r);
    return $sformatf("kind %0d token %0d pos %0d byte %02h len %0d count %0d last %0d",
                     r.kind, r.token_index, r.position, r.out_byte, r.token_length,
                     r.token_count, r.last);
  endfunction

  // port monitor: result check, register writes and byte transfers
  always @(posedge clk_i) begin : watch_ports
    cts_pkg::res_t got;
    cts_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kind         = cts_pkg::kind_e'(kind_o);
        got.token_index  = token_index_o;
        got.position     = position_o;
        got.out_byte     = out_byte_o;
        got.token_length = token_length_o;
        got.token_count  = token_count_o;
        got.last         = last_o;
        if (token_events_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = token_events_q.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("result mismatch: expected %s", show(want));
              $display("                 actual   %s", show(got));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cts_pkg::reg_idx_e'(cfg_idx_i))
          cts_pkg::REG_MODE:    sp_mode    = cts_pkg::mode_e'(cfg_data_i[1:0]);
          cts_pkg::REG_DELIM:   sp_delim   = cfg_data_i;
          cts_pkg::REG_MAX_TOK: sp_max_tok = cfg_data_i[4:0];
          cts_pkg::REG_MAX_LEN: sp_max_len = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) split_byte(in_byte_i);
    end
  end

  // result side stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (pressure_left != 0) begin
      out_stall_i   <= 1'b1;
      pressure_left <= pressure_left - 1;
    end else if (pressure_req) begin
      pressure_req = 1'b0;
      pressure_left <= 400;
      out_stall_i   <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 34);
    end
  end

  function automatic logic [7:0] ws_char();
    case ($urandom_range(3))
      0:       return cts_pkg::CH_SPACE;
      1:       return cts_pkg::CH_TAB;
      2:       return cts_pkg::CH_LF;
      default: return cts_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(25));
  endfunction

  task automatic send_byte(logic [7:0] c);
    if (!steady) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(cts_pkg::CH_NUL);
  endtask

  // wait for every expected result, then for bytes that give none to pass through
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (token_events_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(cts_pkg::reg_idx_e idx, logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // unused upper data bits carry junk
  task automatic set_config(cts_pkg::mode_e md, logic [7:0] dl, logic [4:0] mt,
                            logic [5:0] ml);
    logic [7:0] junk;
    junk = 8'($urandom);
    put_reg(cts_pkg::REG_MODE, {junk[7:2], md});
    put_reg(cts_pkg::REG_DELIM, dl);
    put_reg(cts_pkg::REG_MAX_TOK, {junk[2:0], mt});
    put_reg(cts_pkg::REG_MAX_LEN, {junk[1:0], ml});
    cfg_we_i <= 1'b0;
  endtask

  task automatic roll_config();
    cts_pkg::mode_e md;
    logic [7:0]     dl;
    logic [4:0]     mt;
    logic [5:0]     ml;
    md = cts_pkg::mode_e'($urandom_range(3));
    case ($urandom_range(9))
      0:       dl = cts_pkg::CH_NUL;
      1:       dl = cts_pkg::CH_SPACE;
      2:       dl = 8'($urandom_range(1, 255));
      3:       dl = rand_letter();
      default: dl = cts_pkg::RST_DELIM;
    endcase
    case ($urandom_range(9))
      0:       mt = 5'd0;
      1:       mt = 5'd1;
      2:       mt = 5'($urandom_range(17, 31));
      3:       mt = cts_pkg::RST_MAX_TOK;
      default: mt = 5'($urandom_range(2, 16));
    endcase
    case ($urandom_range(9))
      0:       ml = 6'd0;
      1:       ml = 6'd1;
      2:       ml = cts_pkg::RST_MAX_LEN;
      3:       ml = 6'($urandom_range(33, 63));
      default: ml = 6'($urandom_range(2, 8));
    endcase
    set_config(md, dl, mt, ml);
  endtask

  task automatic send_separator();
    logic [7:0] c;
    case (sp_mode)
      cts_pkg::MODE_WS: repeat ($urandom_range(1, 3)) send_byte(ws_char());
      cts_pkg::MODE_WORDS: begin
        do c = 8'($urandom_range(1, 255)); while (alpha(c));
        send_byte(c);
      end
      default: begin
        if (sp_delim != cts_pkg::CH_NUL) begin
          send_byte(sp_delim);
          if ($urandom_range(5) == 0) send_byte(sp_delim);
        end
        if (sp_mode == cts_pkg::MODE_TRIM && $urandom_range(1) == 0) send_byte(ws_char());
      end
    endcase
  endtask

  task automatic send_random_line();
    int ntok;
    int body;
    int cap;
    cap = (sp_max_len == 0) ? 1 :
          ((sp_max_len > cts_pkg::MAX_LEN) ? cts_pkg::MAX_LEN : sp_max_len);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(0, 40)) send_byte(8'($urandom_range(1, 255)));
    end else begin
      ntok = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      for (int t = 0; t < ntok; t++) begin
        if (sp_mode != cts_pkg::MODE_DELIM && $urandom_range(3) == 0) send_byte(ws_char());
        body = $urandom_range(0, cap + 2);
        for (int i = 0; i < body; i++) begin
          if ($urandom_range(15) == 0) begin
            send_byte(8'($urandom_range(1, 255)));
          end else if (sp_mode == cts_pkg::MODE_TRIM && $urandom_range(7) == 0) begin
            send_byte(ws_char());
          end else if (sp_mode == cts_pkg::MODE_WORDS || $urandom_range(1) == 0) begin
            send_byte(rand_letter());
          end else begin
            send_byte(8'($urandom_range(8'h21, 8'h7e)));
          end
        end
        // sometimes leave the last token without a separator
        if (t + 1 < ntok || $urandom_range(1) == 0) send_separator();
      end
    end
    send_byte(cts_pkg::CH_NUL);
  endtask

  task automatic test_reset_defaults();
    send_line(" Ab\t");
    send_byte(8'h01);
    send_byte(8'hff);
    send_line("\r\n");
  endtask

  task automatic test_delimiter_modes();
    settle();
    set_config(cts_pkg::MODE_DELIM, cts_pkg::RST_DELIM, cts_pkg::RST_MAX_TOK, 6'd2);
    send_line("ab,,c,");
    settle();
    set_config(cts_pkg::MODE_TRIM, ";", 5'd31, 6'd63);
    send_line(" x ;y\t");
  endtask

  task automatic test_words_and_limits();
    settle();
    set_config(cts_pkg::MODE_WORDS, cts_pkg::RST_DELIM, 5'd1, 6'd0);
    send_line("a1bc");
    settle();
    set_config(cts_pkg::MODE_WS, cts_pkg::RST_DELIM, 5'd0, 6'd5);
    send_line("q");
    settle();
    set_config(cts_pkg::MODE_DELIM, cts_pkg::CH_NUL, cts_pkg::RST_MAX_TOK, 6'd2);
    send_line("abc");
  endtask

  task automatic test_mode_change_mid_line();
    settle();
    set_config(cts_pkg::MODE_WS, cts_pkg::RST_DELIM, cts_pkg::RST_MAX_TOK,
               cts_pkg::RST_MAX_LEN);
    send_byte("a");
    send_byte("b");
    settle();
    set_config(cts_pkg::MODE_WORDS, cts_pkg::RST_DELIM, cts_pkg::RST_MAX_TOK,
               cts_pkg::RST_MAX_LEN);
    send_line("c1");
  endtask

  // one-byte tokens give two results per transfer, so the block backs up
  task automatic test_output_backpressure();
    settle();
    set_config(cts_pkg::MODE_DELIM, cts_pkg::RST_DELIM, cts_pkg::RST_MAX_TOK, 6'd1);
    steady = 1'b1;
    pressure_req = 1'b1;
    send_line("abcdefghijklmnopqrstuvwxyz");
    steady = 1'b0;
  endtask

  task automatic test_random_lines();
    int goal;
    int round;
    goal  = 1200;
    round = 0;
    while (live_bytes < goal) begin
      settle();
      roll_config();
      steady = (round == 2);
      repeat (steady ? 15 : $urandom_range(2, 6)) send_random_line();
      steady = 1'b0;
      round++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_delimiter_modes();
    test_words_and_limits();
    test_mode_change_mid_line();
    test_output_backpressure();
    test_random_lines();
    settle();
    fault_count += token_events_q.size();
    if (fault_count == 0) begin
      $display("configurable_token_splitter_top regression: pass");
    end else begin
      $display("configurable_token_splitter_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("configurable_token_splitter_top regression: fail");
    $finish;
  end

endmodule
